[hdl/ptf_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ptf_pkg
// Shared constants and types of the point transform and field-of-view cull.
// ----------------------------------------------------------------------------
package ptf_pkg;

    localparam int COORD_WIDTH_DEF   = 24;
    localparam int ROT_FRAC_BITS_DEF = 16;

    localparam int IN_W        = 24;
    localparam int OUT_W       = 24;
    localparam int COEFF_W     = 24;
    localparam int NUM_COEFFS  = 12;
    localparam int COEFF_IDX_W = 4;
    localparam int PROD_W      = COEFF_W + IN_W;
    localparam int ACC_W       = PROD_W + 4;

    localparam int RANGE_W     = 23;
    localparam int TRIG_W      = 18;
    localparam int SIN_SHIFT   = 16;
    localparam int CFG_IDX_W   = 3;
    localparam int CFG_DATA_W  = 23;

    localparam logic REQ_COEFF = 1'b0;
    localparam logic REQ_POINT = 1'b1;

    localparam logic [CFG_IDX_W-1:0] CFG_MIN_RANGE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_RANGE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SIN_MIN   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SIN_MAX   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_COS_HALF  = 3'd4;

    localparam logic [RANGE_W-1:0]       MIN_RANGE_RST = 23'd102;
    localparam logic [RANGE_W-1:0]       MAX_RANGE_RST = 23'd40960;
    localparam logic signed [TRIG_W-1:0] SIN_MIN_RST   = -18'sd7987;
    localparam logic signed [TRIG_W-1:0] SIN_MAX_RST   = 18'sd51643;
    localparam logic signed [TRIG_W-1:0] COS_HALF_RST  = -18'sd65536;
    localparam logic signed [TRIG_W-1:0] NEG_ONE       = -18'sd65536;

    localparam int ROT_XX_SLOT  = 0;
    localparam int ROT_YY_SLOT  = 4;
    localparam int ROT_ZZ_SLOT  = 8;
    localparam int TRANS_X_SLOT = 9;

    typedef struct packed {
        logic [RANGE_W-1:0]       min_range;
        logic [RANGE_W-1:0]       max_range;
        logic signed [TRIG_W-1:0] sin_min;
        logic signed [TRIG_W-1:0] sin_max;
        logic signed [TRIG_W-1:0] cos_half;
    } ptf_limits_t;

endpackage
`default_nettype wire

[hdl/ptf_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ptf_in_if / ptf_out_if
// Request and result channels, valid/ready handshake.
// ----------------------------------------------------------------------------
interface ptf_in_if;
    logic                                  valid;
    logic                                  ready;
    logic                                  req_type;
    logic [ptf_pkg::COEFF_IDX_W-1:0]       coeff_index;
    logic signed [ptf_pkg::COEFF_W-1:0]    coeff_value;
    logic signed [ptf_pkg::IN_W-1:0]       world_x;
    logic signed [ptf_pkg::IN_W-1:0]       world_y;
    logic signed [ptf_pkg::IN_W-1:0]       world_z;
    logic                                  frame_end;

    modport source (output valid, req_type, coeff_index, coeff_value,
                    world_x, world_y, world_z, frame_end, input ready);
    modport sink   (input valid, req_type, coeff_index, coeff_value,
                    world_x, world_y, world_z, frame_end, output ready);
endinterface

interface ptf_out_if;
    logic                               valid;
    logic                               ready;
    logic signed [ptf_pkg::OUT_W-1:0]   sensor_x;
    logic signed [ptf_pkg::OUT_W-1:0]   sensor_y;
    logic signed [ptf_pkg::OUT_W-1:0]   sensor_z;
    logic                               kept;
    logic                               frame_last;

    modport source (output valid, sensor_x, sensor_y, sensor_z, kept, frame_last,
                    input ready);
    modport sink   (input valid, sensor_x, sensor_y, sensor_z, kept, frame_last,
                    output ready);
endinterface
`default_nettype wire

[hdl/ptf_transform.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ptf_transform
// Coefficient store and two-stage rotate, round, translate and saturate.
// ----------------------------------------------------------------------------
module ptf_transform #(
    parameter int COORD_WIDTH   = ptf_pkg::COORD_WIDTH_DEF,
    parameter int ROT_FRAC_BITS = ptf_pkg::ROT_FRAC_BITS_DEF
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   load_en,
    input  wire logic [ptf_pkg::COEFF_IDX_W-1:0]        load_idx,
    input  wire logic signed [ptf_pkg::COEFF_W-1:0]     load_val,
    input  wire logic [1:0]                             en,
    input  wire logic signed [ptf_pkg::IN_W-1:0]        world_x,
    input  wire logic signed [ptf_pkg::IN_W-1:0]        world_y,
    input  wire logic signed [ptf_pkg::IN_W-1:0]        world_z,
    output logic signed [COORD_WIDTH-1:0]               qx,
    output logic signed [COORD_WIDTH-1:0]               qy,
    output logic signed [COORD_WIDTH-1:0]               qz
);

    localparam int AW = ptf_pkg::ACC_W;
    localparam logic signed [AW-1:0] ROUND   = AW'(1) << (ROT_FRAC_BITS - 1);
    localparam logic signed [AW-1:0] SAT_MAX = signed'(AW'({(COORD_WIDTH-1){1'b1}}));
    localparam logic signed [AW-1:0] SAT_MIN = -SAT_MAX - AW'(1);
    localparam logic signed [ptf_pkg::COEFF_W-1:0] ONE =
        ptf_pkg::COEFF_W'(1) << ROT_FRAC_BITS;

    logic signed [ptf_pkg::COEFF_W-1:0] coeff_reg [ptf_pkg::NUM_COEFFS];
    logic signed [ptf_pkg::PROD_W-1:0]  prod_reg  [9];
    logic signed [ptf_pkg::COEFF_W-1:0] trans_reg [3];
    logic signed [ptf_pkg::IN_W-1:0]    pt        [3];
    logic signed [COORD_WIDTH-1:0]      q_reg     [3];
    logic signed [COORD_WIDTH-1:0]      q_next    [3];

    assign pt[0] = world_x;
    assign pt[1] = world_y;
    assign pt[2] = world_z;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < ptf_pkg::NUM_COEFFS; i++)
            begin
                coeff_reg[i] <= (i == ptf_pkg::ROT_XX_SLOT || i == ptf_pkg::ROT_YY_SLOT ||
                                 i == ptf_pkg::ROT_ZZ_SLOT) ? ONE : '0;
            end
        end
        else if (load_en && (load_idx < ptf_pkg::COEFF_IDX_W'(ptf_pkg::NUM_COEFFS)))
        begin
            coeff_reg[load_idx] <= load_val;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            for (int r = 0; r < 3; r++)
            begin
                for (int c = 0; c < 3; c++)
                begin
                    prod_reg[r*3+c] <= coeff_reg[r*3+c] * pt[c];
                end
                trans_reg[r] <= coeff_reg[ptf_pkg::TRANS_X_SLOT + r];
            end
        end
    end

    always_comb
    begin
        logic signed [AW-1:0] acc;
        logic signed [AW-1:0] v;
        for (int r = 0; r < 3; r++)
        begin
            acc = AW'(prod_reg[r*3]) + AW'(prod_reg[r*3+1]) + AW'(prod_reg[r*3+2]) + ROUND;
            v   = (acc >>> ROT_FRAC_BITS) + AW'(trans_reg[r]);
            if (v > SAT_MAX)
                q_next[r] = SAT_MAX[COORD_WIDTH-1:0];
            else if (v < SAT_MIN)
                q_next[r] = SAT_MIN[COORD_WIDTH-1:0];
            else
                q_next[r] = v[COORD_WIDTH-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            for (int r = 0; r < 3; r++)
            begin
                q_reg[r] <= q_next[r];
            end
        end
    end

    assign qx = q_reg[0];
    assign qy = q_reg[1];
    assign qz = q_reg[2];

endmodule
`default_nettype wire

[hdl/ptf_isqrt.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ptf_isqrt
// Pipelined integer square root, two result digits per stage.
// ----------------------------------------------------------------------------
module ptf_isqrt #(
    parameter int ROOT_W = ptf_pkg::COORD_WIDTH_DEF
) (
    input  wire logic                         clk,
    input  wire logic [(ROOT_W+1)/2-1:0]      en,
    input  wire logic [2*ROOT_W-1:0]          radicand,
    output logic [ROOT_W-1:0]                 root
);

    localparam int NS    = (ROOT_W + 1) / 2;
    localparam int NSTEP = 2 * NS;
    localparam int RMW   = NSTEP + 2;
    localparam int RADW  = 2 * NSTEP;

    for (genvar s = 0; s < NS; s++)
    begin : g_stage
        logic [RMW-1:0]   rem_in, rem_next, rem_reg;
        logic [NSTEP-1:0] root_in, root_next, root_reg;
        logic [RADW-1:0]  rad_in, rad_next, rad_reg;

        if (s == 0)
        begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
            assign rad_in  = RADW'(radicand);
        end
        else
        begin : g_rest
            assign rem_in  = g_stage[s-1].rem_reg;
            assign root_in = g_stage[s-1].root_reg;
            assign rad_in  = g_stage[s-1].rad_reg;
        end

        always_comb
        begin
            logic [RMW-1:0] trial;
            rem_next  = rem_in;
            root_next = root_in;
            rad_next  = rad_in;
            for (int k = 0; k < 2; k++)
            begin
                rem_next = {rem_next[RMW-3:0], rad_next[RADW-1 -: 2]};
                rad_next = rad_next << 2;
                trial    = {root_next, 2'b01};
                if (rem_next >= trial)
                begin
                    rem_next  = rem_next - trial;
                    root_next = {root_next[NSTEP-2:0], 1'b1};
                end
                else
                begin
                    root_next = {root_next[NSTEP-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge clk)
        begin
            if (en[s])
            begin
                rem_reg  <= rem_next;
                root_reg <= root_next;
                rad_reg  <= rad_next;
            end
        end
    end

    assign root = g_stage[NS-1].root_reg[ROOT_W-1:0];

endmodule
`default_nettype wire

[hdl/ptf_cull.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ptf_cull
// Range, elevation and azimuth limit tests, two stages.
// ----------------------------------------------------------------------------
module ptf_cull #(
    parameter int COORD_WIDTH = ptf_pkg::COORD_WIDTH_DEF
) (
    input  wire logic                          clk,
    input  wire logic [1:0]                    en,
    input  wire ptf_pkg::ptf_limits_t          lim,
    input  wire logic signed [COORD_WIDTH-1:0] x,
    input  wire logic signed [COORD_WIDTH-1:0] z,
    input  wire logic [COORD_WIDTH-1:0]        r,
    input  wire logic [COORD_WIDTH-1:0]        h,
    output logic                               kept
);

    localparam int PW  = COORD_WIDTH + 20;
    localparam int RGW = (COORD_WIDTH > ptf_pkg::RANGE_W) ? COORD_WIDTH : ptf_pkg::RANGE_W;

    logic signed [COORD_WIDTH:0] r_s;
    logic signed [COORD_WIDTH:0] h_s;
    logic signed [PW-1:0] lo_next, hi_next, ch_next;
    logic range_ok_reg, full_reg, kept_reg;
    logic signed [PW-1:0] zs_reg, xs_reg, lo_reg, hi_reg, ch_reg;

    assign r_s = signed'({1'b0, r});
    assign h_s = signed'({1'b0, h});
    assign lo_next = lim.sin_min * r_s;
    assign hi_next = lim.sin_max * r_s;
    assign ch_next = lim.cos_half * h_s;

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            range_ok_reg <= (RGW'(r) >= RGW'(lim.min_range)) &&
                            (RGW'(r) <= RGW'(lim.max_range));
            full_reg     <= (lim.cos_half <= ptf_pkg::NEG_ONE);
            zs_reg       <= PW'(z) <<< ptf_pkg::SIN_SHIFT;
            xs_reg       <= PW'(x) <<< ptf_pkg::SIN_SHIFT;
            lo_reg       <= lo_next;
            hi_reg       <= hi_next;
            ch_reg       <= ch_next;
        end
        if (en[1])
        begin
            kept_reg <= range_ok_reg && (lo_reg <= zs_reg) && (zs_reg <= hi_reg) &&
                        (full_reg || (xs_reg >= ch_reg));
        end
    end

    assign kept = kept_reg;

endmodule
`default_nettype wire

[hdl/point_transform_fov_cull_unit.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// point_transform_fov_cull_unit
// Rigid transform of world points into the sensor frame with keep flag.
// ----------------------------------------------------------------------------
// Takes one item per clock. A coefficient item updates the transform in the
// cycle it is accepted and gives no result; a point item gives one result
// after the transform, squaring, square root and cull stages. The pipelined
// square roots of range and horizontal range resolve two root digits per
// stage. Stalls on the result side hold the whole pipeline but empty stages
// keep filling, so input stays open until it is full.
module point_transform_fov_cull_unit #(
    parameter int COORD_WIDTH   = ptf_pkg::COORD_WIDTH_DEF,
    parameter int ROT_FRAC_BITS = ptf_pkg::ROT_FRAC_BITS_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    ptf_in_if.sink                                 point_in,
    ptf_out_if.source                              result_out,
    input  wire logic                              cfg_we,
    input  wire logic [ptf_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [ptf_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int NS   = (COORD_WIDTH + 1) / 2;
    localparam int S    = 6 + NS;
    localparam int SQ_W = 2 * COORD_WIDTH;
    localparam int SQ0  = 4;
    localparam int CU0  = 4 + NS;

    logic [S-1:0] valid_reg;
    logic [S-1:0] stage_en;
    logic         accept;
    logic         frame_reg [S];
    ptf_pkg::ptf_limits_t lim_reg;

    logic signed [COORD_WIDTH-1:0] qx_s1, qy_s1, qz_s1;
    logic signed [COORD_WIDTH-1:0] qx_reg [2:S-1];
    logic signed [COORD_WIDTH-1:0] qy_reg [2:S-1];
    logic signed [COORD_WIDTH-1:0] qz_reg [2:S-1];
    logic [SQ_W-1:0] sqx_reg, sqy_reg, sqz_reg, h2_reg, r2_reg;
    logic [COORD_WIDTH-1:0] r_root, h_root;
    logic kept;

    always_comb
    begin
        stage_en[S-1] = !valid_reg[S-1] || result_out.ready;
        for (int j = S - 2; j >= 0; j--)
        begin
            stage_en[j] = !valid_reg[j] || stage_en[j+1];
        end
    end

    assign point_in.ready = stage_en[0];
    assign accept         = point_in.valid && stage_en[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (stage_en[0])
                valid_reg[0] <= point_in.valid && (point_in.req_type == ptf_pkg::REQ_POINT);
            for (int j = 1; j < S; j++)
            begin
                if (stage_en[j])
                    valid_reg[j] <= valid_reg[j-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            lim_reg.min_range <= ptf_pkg::MIN_RANGE_RST;
            lim_reg.max_range <= ptf_pkg::MAX_RANGE_RST;
            lim_reg.sin_min   <= ptf_pkg::SIN_MIN_RST;
            lim_reg.sin_max   <= ptf_pkg::SIN_MAX_RST;
            lim_reg.cos_half  <= ptf_pkg::COS_HALF_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                ptf_pkg::CFG_MIN_RANGE: lim_reg.min_range <= cfg_data;
                ptf_pkg::CFG_MAX_RANGE: lim_reg.max_range <= cfg_data;
                ptf_pkg::CFG_SIN_MIN:   lim_reg.sin_min   <= signed'(cfg_data[ptf_pkg::TRIG_W-1:0]);
                ptf_pkg::CFG_SIN_MAX:   lim_reg.sin_max   <= signed'(cfg_data[ptf_pkg::TRIG_W-1:0]);
                ptf_pkg::CFG_COS_HALF:  lim_reg.cos_half  <= signed'(cfg_data[ptf_pkg::TRIG_W-1:0]);
                default: ;
            endcase
        end
    end

    ptf_transform #(
        .COORD_WIDTH   (COORD_WIDTH),
        .ROT_FRAC_BITS (ROT_FRAC_BITS)
    ) u_transform (
        .clk      (clk),
        .rst_n    (rst_n),
        .load_en  (accept && (point_in.req_type == ptf_pkg::REQ_COEFF)),
        .load_idx (point_in.coeff_index),
        .load_val (point_in.coeff_value),
        .en       (stage_en[1:0]),
        .world_x  (point_in.world_x),
        .world_y  (point_in.world_y),
        .world_z  (point_in.world_z),
        .qx       (qx_s1),
        .qy       (qy_s1),
        .qz       (qz_s1)
    );

    always_ff @(posedge clk)
    begin
        if (stage_en[0])
            frame_reg[0] <= point_in.frame_end;
        for (int j = 1; j < S; j++)
        begin
            if (stage_en[j])
                frame_reg[j] <= frame_reg[j-1];
        end
        if (stage_en[2])
        begin
            qx_reg[2] <= qx_s1;
            qy_reg[2] <= qy_s1;
            qz_reg[2] <= qz_s1;
            sqx_reg   <= SQ_W'(qx_s1 * qx_s1);
            sqy_reg   <= SQ_W'(qy_s1 * qy_s1);
            sqz_reg   <= SQ_W'(qz_s1 * qz_s1);
        end
        for (int j = 3; j < S; j++)
        begin
            if (stage_en[j])
            begin
                qx_reg[j] <= qx_reg[j-1];
                qy_reg[j] <= qy_reg[j-1];
                qz_reg[j] <= qz_reg[j-1];
            end
        end
        if (stage_en[3])
        begin
            h2_reg <= sqx_reg + sqy_reg;
            r2_reg <= sqx_reg + sqy_reg + sqz_reg;
        end
    end

    ptf_isqrt #(.ROOT_W(COORD_WIDTH)) u_range_root (
        .clk      (clk),
        .en       (stage_en[SQ0 +: NS]),
        .radicand (r2_reg),
        .root     (r_root)
    );

    ptf_isqrt #(.ROOT_W(COORD_WIDTH)) u_horiz_root (
        .clk      (clk),
        .en       (stage_en[SQ0 +: NS]),
        .radicand (h2_reg),
        .root     (h_root)
    );

    ptf_cull #(.COORD_WIDTH(COORD_WIDTH)) u_cull (
        .clk  (clk),
        .en   (stage_en[CU0 +: 2]),
        .lim  (lim_reg),
        .x    (qx_reg[CU0-1]),
        .z    (qz_reg[CU0-1]),
        .r    (r_root),
        .h    (h_root),
        .kept (kept)
    );

    assign result_out.valid      = valid_reg[S-1];
    assign result_out.sensor_x   = ptf_pkg::OUT_W'(qx_reg[S-1]);
    assign result_out.sensor_y   = ptf_pkg::OUT_W'(qy_reg[S-1]);
    assign result_out.sensor_z   = ptf_pkg::OUT_W'(qz_reg[S-1]);
    assign result_out.kept       = kept;
    assign result_out.frame_last = frame_reg[S-1];

endmodule
`default_nettype wire
